@@ src/nglp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nglp_pkg: shared definitions for the GLL position parser
// Character codes, field offsets in the captured sentence, conversion
// constants and the item type that passes from the capture front end,
// through the queue, to the conversion back end.
// ----------------------------------------------------------------------------
package nglp_pkg;

  // Default capture buffer depth in bytes.
  localparam int unsigned DEFAULT_BUFFER_DEPTH = 64;

  // ASCII codes that steer the capture.
  localparam logic [7:0] CHAR_L    = 8'h4C;
  localparam logic [7:0] CHAR_V    = 8'h56;
  localparam logic [7:0] CHAR_CR   = 8'h0D;
  localparam logic [7:0] CHAR_N    = 8'h4E;
  localparam logic [7:0] CHAR_E    = 8'h45;
  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_NINE = 8'h39;

  // Digit counts of each coordinate (degrees, minutes, minute fraction).
  localparam int unsigned LAT_DIGITS = 9;
  localparam int unsigned LON_DIGITS = 10;

  // Byte offsets after the start character, most significant digit first.
  localparam int unsigned LAT_OFS [LAT_DIGITS] = '{1, 2, 3, 4, 6, 7, 8, 9, 10};
  localparam int unsigned LON_OFS [LON_DIGITS] =
    '{14, 15, 16, 17, 18, 20, 21, 22, 23, 24};
  localparam int unsigned NS_OFS = 12;
  localparam int unsigned EW_OFS = 26;

  // Conversion widths and constants.
  localparam int unsigned DEG_W   = 10;  // up to 999 degrees
  localparam int unsigned MIN_W   = 24;  // minutes in 1e-5 units, up to 9999999
  localparam int unsigned TRI_W   = 26;  // 5 * minutes + 1
  localparam int unsigned QUO_W   = 24;  // rounded minutes in 1e-7 degree
  localparam int unsigned SCL_W   = 34;  // degrees times 1e7
  localparam int unsigned MAG_W   = 35;  // sum before saturation
  localparam int unsigned PROD_W  = TRI_W + 32;
  localparam int unsigned RECIP_SHIFT = 33;

  localparam logic [31:0]      DIV3_RECIP = 32'hAAAAAAAB;
  localparam logic [SCL_W-1:0] DEG_SCALE  = SCL_W'(10000000);
  localparam logic [MAG_W-1:0] LAT_LIMIT  = MAG_W'(900000000);
  localparam logic [MAG_W-1:0] LON_LIMIT  = MAG_W'(1800000000);

  // Depth of the queue between front and back end.
  localparam int unsigned QUEUE_DEPTH = 2;

  // One finished sentence, as digit values and sign flags.
  typedef struct packed {
    logic [LAT_DIGITS-1:0][3:0] lat_dig;
    logic [LON_DIGITS-1:0][3:0] lon_dig;
    logic                       north;
    logic                       east;
    logic                       valid;
  } job_t;

endpackage

@@ src/nmea_gll_position_parser.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nmea_gll_position_parser: GLL sentence position parser
// Usage: feed received UART bytes on the input channel (in_valid_i,
// in_stall_o, rx_byte_i). An 'L' starts a capture; a carriage return ends it
// and yields one item on the output channel (out_valid_o, out_stall_i) with
// latitude and longitude in 1e-7 degree and a valid flag that a 'V' clears.
// Throughput: one byte per cycle while in_stall_o is low, and one result per
// cycle out of the conversion pipeline while out_stall_i is low.
// Path: the result of an accepted carriage return passes through the queue
// slot, decode stage, multiply stage and output register, in that order.
// A stalled receiver freezes the conversion pipeline once a result is waiting;
// the two-entry queue then fills and in_stall_o rises, holding off the byte stream.
// Reset clears the capture state, queue and pipeline valid flags; stored
// field bytes keep no reset value and are filled by the next sentence.
// ----------------------------------------------------------------------------
module nmea_gll_position_parser import nglp_pkg::*; #(
  parameter int unsigned BUFFER_DEPTH = DEFAULT_BUFFER_DEPTH
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [7:0]         rx_byte_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [30:0] latitude_e7_o,
  output logic signed [31:0] longitude_e7_o,
  output logic               position_valid_o
);

  logic accept;
  logic push;
  logic pop;
  logic full;
  logic empty;
  job_t push_job;
  job_t pop_job;

  assign in_stall_o = full;
  assign accept     = in_valid_i && !in_stall_o;

  // Capture front end.
  nglp_front #(
    .BUFFER_DEPTH(BUFFER_DEPTH)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .rx_byte_i(rx_byte_i),
    .push_o   (push),
    .job_o    (push_job)
  );

  // Queue of finished sentences.
  nglp_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(push_job),
    .pop_i      (pop),
    .pop_data_o (pop_job),
    .full_o     (full),
    .empty_o    (empty)
  );

  // Conversion back end.
  nglp_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .empty_i         (empty),
    .job_i           (pop_job),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .latitude_e7_o   (latitude_e7_o),
    .longitude_e7_o  (longitude_e7_o),
    .position_valid_o(position_valid_o)
  );

  // A job is only pushed when the queue has room.
  assert property (@(posedge clk_i) disable iff (!rst_ni) push |-> !full)
    else $error("job pushed into a full queue");

  // A result without a fix carries zero coordinates.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !position_valid_o) |-> (latitude_e7_o == '0 && longitude_e7_o == '0))
    else $error("invalid position with nonzero coordinates");

  // Saturation keeps both coordinates inside their ranges.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (latitude_e7_o <= 31'sd900000000 && latitude_e7_o >= -31'sd900000000
                     && longitude_e7_o <= 32'sd1800000000
                     && longitude_e7_o >= -32'sd1800000000))
    else $error("coordinate out of range");

  // The queue never pops while empty.
  assert property (@(posedge clk_i) disable iff (!rst_ni) pop |-> !empty)
    else $error("pop from an empty queue");

endmodule

@@ src/nglp_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nglp_front: sentence capture front end
// Accepts one byte per cycle, tracks the capture state and keeps the digit
// values and sign flags found at the fixed field offsets. A carriage return
// during a capture hands the finished sentence to the queue as one job.
// ----------------------------------------------------------------------------
module nglp_front import nglp_pkg::*; #(
  parameter int unsigned BUFFER_DEPTH = DEFAULT_BUFFER_DEPTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [7:0] rx_byte_i,
  output logic       push_o,
  output job_t       job_o
);

  localparam int unsigned PosW = $clog2(BUFFER_DEPTH + 1);

  logic            active_q, active_d;
  logic            valid_q, valid_d;
  logic [PosW-1:0] wpos_q, wpos_d;

  logic [LAT_DIGITS-1:0][3:0] lat_dig_q;
  logic [LON_DIGITS-1:0][3:0] lon_dig_q;
  logic                       north_q;
  logic                       east_q;

  logic       is_l, is_cr, is_v, is_digit;
  logic       store;
  logic [3:0] digit;

  // Classify the incoming byte.
  always_comb begin
    is_l     = (rx_byte_i == CHAR_L);
    is_cr    = (rx_byte_i == CHAR_CR);
    is_v     = (rx_byte_i == CHAR_V);
    is_digit = (rx_byte_i >= CHAR_ZERO) && (rx_byte_i <= CHAR_NINE);
    digit    = is_digit ? 4'(rx_byte_i - CHAR_ZERO) : 4'd0;
  end

  // Capture control: start, store, end of sentence.
  always_comb begin
    active_d = active_q;
    valid_d  = valid_q;
    wpos_d   = wpos_q;
    store    = 1'b0;
    push_o   = 1'b0;
    if (accept_i) begin
      if (is_l) begin
        active_d = 1'b1;
        valid_d  = 1'b1;
        wpos_d   = '0;
      end else if (active_q) begin
        if (is_cr) begin
          active_d = 1'b0;
          push_o   = 1'b1;
        end else begin
          if (is_v) begin
            valid_d = 1'b0;
          end
          if (wpos_q < PosW'(BUFFER_DEPTH)) begin
            store  = 1'b1;
            wpos_d = wpos_q + 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      valid_q  <= 1'b0;
      wpos_q   <= '0;
    end else begin
      active_q <= active_d;
      valid_q  <= valid_d;
      wpos_q   <= wpos_d;
    end
  end

  // Field storage: one register per offset that the conversion reads.
  for (genvar k = 0; k < LAT_DIGITS; k++) begin : g_lat
    always_ff @(posedge clk_i) begin
      if (store && (wpos_q == PosW'(LAT_OFS[k]))) begin
        lat_dig_q[k] <= digit;
      end
    end
  end

  for (genvar k = 0; k < LON_DIGITS; k++) begin : g_lon
    always_ff @(posedge clk_i) begin
      if (store && (wpos_q == PosW'(LON_OFS[k]))) begin
        lon_dig_q[k] <= digit;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (store && (wpos_q == PosW'(NS_OFS))) begin
      north_q <= (rx_byte_i == CHAR_N);
    end
    if (store && (wpos_q == PosW'(EW_OFS))) begin
      east_q <= (rx_byte_i == CHAR_E);
    end
  end

  // The carriage return is not stored, so the registers are complete here.
  always_comb begin
    job_o.lat_dig = lat_dig_q;
    job_o.lon_dig = lon_dig_q;
    job_o.north   = north_q;
    job_o.east    = east_q;
    job_o.valid   = valid_q;
  end

endmodule

@@ src/nglp_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nglp_queue: job queue between front and back end
// A small circular queue of finished sentences. The front end pushes, the
// back end pops; the full flag holds off the byte input.
// ----------------------------------------------------------------------------
module nglp_queue import nglp_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t push_data_i,
  input  logic pop_i,
  output job_t pop_data_o,
  output logic full_o,
  output logic empty_o
);

  localparam int unsigned PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

  job_t            entry_q [QUEUE_DEPTH];
  logic [PtrW-1:0] wptr_q, wptr_d;
  logic [PtrW-1:0] rptr_q, rptr_d;
  logic [CntW-1:0] count_q, count_d;

  assign full_o     = (count_q == CntW'(QUEUE_DEPTH));
  assign empty_o    = (count_q == '0);
  assign pop_data_o = entry_q[rptr_q];

  // Pointer and fill count update.
  always_comb begin
    wptr_d  = wptr_q;
    rptr_d  = rptr_q;
    count_d = count_q;
    if (push_i) begin
      wptr_d = (wptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (pop_i) begin
      rptr_d = (rptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wptr_q] <= push_data_i;
    end
  end

endmodule

@@ src/nglp_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nglp_back: coordinate conversion back end
// Three-stage pipeline: decimal digits to degrees and minutes, constant
// multiplies (degrees times 1e7, minutes times 5 over 3, rounded), then sum,
// saturation and sign. The last stage is the output register.
// ----------------------------------------------------------------------------
module nglp_back import nglp_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               empty_i,
  input  job_t               job_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [30:0] latitude_e7_o,
  output logic signed [31:0] longitude_e7_o,
  output logic               position_valid_o
);

  typedef struct packed {
    logic [DEG_W-1:0] deg;
    logic [MIN_W-1:0] mins;
    logic             pos;
  } dec_t;

  typedef struct packed {
    logic [SCL_W-1:0] scaled;
    logic [QUO_W-1:0] quo;
    logic             pos;
  } mul_t;

  // Five fraction digits to an integer, as a weighted sum of the digits.
  function automatic logic [16:0] dec_frac(input logic [3:0] a, input logic [3:0] b,
                                           input logic [3:0] c, input logic [3:0] d,
                                           input logic [3:0] e);
    logic [16:0] v;
    v = 17'(a) * 17'd10000 + 17'(b) * 17'd1000 + 17'(c) * 17'd100
        + 17'(d) * 17'd10 + 17'(e);
    return v;
  endfunction

  // Whole minutes and fraction to minutes in 1e-5 units.
  function automatic logic [MIN_W-1:0] dec_mins(input logic [3:0] m1, input logic [3:0] m0,
                                                input logic [16:0] frac);
    logic [6:0] mm;
    mm = 7'(m1 * 7'd10) + 7'(m0);
    return MIN_W'(MIN_W'(mm) * MIN_W'(100000)) + MIN_W'(frac);
  endfunction

  // Degrees times 1e7 and round(minutes * 5 / 3) by reciprocal multiply.
  function automatic mul_t scale(input dec_t d);
    mul_t              r;
    logic [TRI_W-1:0]  tri_v;
    logic [PROD_W-1:0] prod;
    tri_v    = TRI_W'(TRI_W'(d.mins) * TRI_W'(5)) + TRI_W'(1);
    prod     = PROD_W'(tri_v) * PROD_W'(DIV3_RECIP);
    r.quo    = prod[RECIP_SHIFT +: QUO_W];
    r.scaled = SCL_W'(d.deg) * DEG_SCALE;
    r.pos    = d.pos;
    return r;
  endfunction

  // Sum, clamp to the limit, apply the sign.
  function automatic logic [31:0] finish(input mul_t m, input logic [MAG_W-1:0] limit);
    logic [MAG_W-1:0] mag;
    logic [31:0]      val;
    mag = MAG_W'(m.scaled) + MAG_W'(m.quo);
    if (mag > limit) begin
      mag = limit;
    end
    val = mag[31:0];
    return m.pos ? val : 32'(-val);
  endfunction

  logic adv;
  dec_t s1_lat_q, s1_lon_q, s1_lat_d, s1_lon_d;
  mul_t s2_lat_q, s2_lon_q;
  logic s1_ok_q, s2_ok_q;
  logic s1_v_q, s2_v_q, out_v_q;
  logic [31:0] lat_res, lon_res;

  // The pipeline moves whenever the output register is free or being taken.
  assign adv   = !out_v_q || !out_stall_i;
  assign pop_o = adv && !empty_i;

  // Stage one: decimal decode of both coordinates.
  always_comb begin
    s1_lat_d.deg  = DEG_W'(7'(job_i.lat_dig[0] * 7'd10) + 7'(job_i.lat_dig[1]));
    s1_lat_d.mins = dec_mins(job_i.lat_dig[2], job_i.lat_dig[3],
                             dec_frac(job_i.lat_dig[4], job_i.lat_dig[5], job_i.lat_dig[6],
                                      job_i.lat_dig[7], job_i.lat_dig[8]));
    s1_lat_d.pos  = job_i.north;
    s1_lon_d.deg  = DEG_W'(DEG_W'(job_i.lon_dig[0]) * DEG_W'(100))
                    + DEG_W'(DEG_W'(job_i.lon_dig[1]) * DEG_W'(10))
                    + DEG_W'(job_i.lon_dig[2]);
    s1_lon_d.mins = dec_mins(job_i.lon_dig[3], job_i.lon_dig[4],
                             dec_frac(job_i.lon_dig[5], job_i.lon_dig[6], job_i.lon_dig[7],
                                      job_i.lon_dig[8], job_i.lon_dig[9]));
    s1_lon_d.pos  = job_i.east;
  end

  // Stage three logic.
  assign lat_res = finish(s2_lat_q, LAT_LIMIT);
  assign lon_res = finish(s2_lon_q, LON_LIMIT);

  // Stage valid flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else if (adv) begin
      s1_v_q  <= pop_o;
      s2_v_q  <= s1_v_q;
      out_v_q <= s2_v_q;
    end
  end

  // Stage payload registers.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_lat_q <= s1_lat_d;
      s1_lon_q <= s1_lon_d;
      s1_ok_q  <= job_i.valid;
      s2_lat_q <= scale(s1_lat_q);
      s2_lon_q <= scale(s1_lon_q);
      s2_ok_q  <= s1_ok_q;
      latitude_e7_o    <= s2_ok_q ? $signed(lat_res[30:0]) : '0;
      longitude_e7_o   <= s2_ok_q ? $signed(lon_res) : '0;
      position_valid_o <= s2_ok_q;
    end
  end

  assign out_valid_o = out_v_q;

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the GLL position parser
// Feeds GLL sentences, broken sentences and line noise into the byte channel
// with random gaps, keeps its own copy of the capture buffer to work out the
// expected position of every carriage return, and compares each result
// field by field while the receiver stalls at random.
// ----------------------------------------------------------------------------
module testbench;
  import nglp_pkg::*;

  localparam int unsigned DEPTH        = DEFAULT_BUFFER_DEPTH;
  localparam int unsigned RANDOM_ITEMS = 800;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam longint      LAT_MAX      = 900000000;
  localparam longint      LON_MAX      = 1800000000;

  typedef logic [7:0] bytes_t [$];

  typedef struct {
    logic signed [30:0] lat;
    logic signed [31:0] lon;
    logic               valid;
  } position_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [7:0]         rx_byte_i = 8'h00;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic signed [30:0] latitude_e7_o;
  logic signed [31:0] longitude_e7_o;
  logic               position_valid_o;

  // Shadow of the parser state.
  logic        capturing = 1'b0;
  logic        fix_ok = 1'b0;
  int unsigned fill_count = 0;
  logic [7:0]  sentence_buf [DEPTH];

  position_t   pending_fixes [$];
  int unsigned captured_count = 0;
  int unsigned mismatch_count = 0;

  // Knobs shared by the stimulus and the result sink.
  bit no_gaps = 1'b0;
  bit quiet_rx = 1'b0;
  bit hold_request = 1'b0;

  nmea_gll_position_parser dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .rx_byte_i       (rx_byte_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .latitude_e7_o   (latitude_e7_o),
    .longitude_e7_o  (longitude_e7_o),
    .position_valid_o(position_valid_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Value of a run of digit bytes; anything that is not a digit counts as zero.
  function automatic longint digit_run(int unsigned first, int unsigned count);
    longint value;
    logic [7:0] c;
    value = 0;
    for (int unsigned i = 0; i < count; i++) begin
      c = sentence_buf[first + i];
      value = value * 10 + ((c >= CHAR_ZERO && c <= CHAR_NINE) ? longint'(c - CHAR_ZERO) : 0);
    end
    return value;
  endfunction

  // Degrees and decimal minutes to 1e-7 degree, rounded half up, saturated, signed.
  function automatic longint fix_coord(int unsigned deg_pos, int unsigned deg_count,
                                       int unsigned frac_pos, int unsigned sign_pos,
                                       logic [7:0] plus_char, longint limit);
    longint minutes;
    longint mag;
    minutes = digit_run(deg_pos + deg_count, 2) * 100000 + digit_run(frac_pos, 5);
    mag = digit_run(deg_pos, deg_count) * 10000000 + (minutes * 5 + 1) / 3;
    if (mag > limit) begin
      mag = limit;
    end
    return (sentence_buf[sign_pos] == plus_char) ? mag : -mag;
  endfunction

  // Advance the shadow state by one accepted byte and queue any finished fix.
  function automatic void gll_track_byte(logic [7:0] b);
    position_t fix;
    if (b == CHAR_L) begin
      capturing = 1'b1;
      fix_ok = 1'b1;
      fill_count = 0;
      captured_count++;
    end else if (capturing) begin
      captured_count++;
      if (b == CHAR_CR) begin
        capturing = 1'b0;
        fix.valid = fix_ok;
        fix.lat = '0;
        fix.lon = '0;
        if (fix_ok) begin
          fix.lat = 31'(fix_coord(1, 2, 6, NS_OFS, CHAR_N, LAT_MAX));
          fix.lon = 32'(fix_coord(14, 3, 20, EW_OFS, CHAR_E, LON_MAX));
        end
        pending_fixes.push_back(fix);
      end else begin
        // A 'V' clears the fix even when the buffer is already full.
        if (b == CHAR_V) begin
          fix_ok = 1'b0;
        end
        if (fill_count < DEPTH) begin
          sentence_buf[fill_count] = b;
          fill_count++;
        end
      end
    end
  endfunction

  function automatic bytes_t to_bytes(string s);
    bytes_t q;
    for (int i = 0; i < s.len(); i++) begin
      q.push_back(s[i]);
    end
    return q;
  endfunction

  // A well-formed GLL sentence body with random content, without the line end.
  function automatic bytes_t random_sentence();
    return to_bytes($sformatf("$GPGLL,%02d%02d.%05d,%s,%03d%02d.%05d,%s,%06d.00,%s*%02X",
      $urandom_range(0, 99), $urandom_range(0, 99), $urandom_range(0, 99999),
      $urandom_range(0, 1) ? "N" : "S",
      $urandom_range(0, 999), $urandom_range(0, 99), $urandom_range(0, 99999),
      $urandom_range(0, 1) ? "E" : "W",
      $urandom_range(0, 235959), $urandom_range(0, 7) == 0 ? "V" : "A",
      $urandom_range(0, 255)));
  endfunction

  // Offer one byte after a random gap and hold it until the parser takes it.
  task automatic send_byte(logic [7:0] b);
    int unsigned gap;
    gap = no_gaps ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i <= b;
    do @(posedge clk_i); while (in_stall_o);
    gll_track_byte(b);
  endtask

  task automatic send_bytes(bytes_t q);
    foreach (q[i]) begin
      send_byte(q[i]);
    end
  endtask

  // Typical sentences, the zero position with either sign.
  task automatic test_full_sentence();
    // The first sentence fills every field offset, so later short ones read old bytes.
    send_bytes(to_bytes("$GPGLL,4916.45000,N,12311.12000,W,225444.00,A*1D\r\n"));
    send_bytes(to_bytes("L,0000.00000,S,00000.00000,W\r"));
    send_bytes(to_bytes("L,0000.00000,N,00000.00000,E\r"));
  endtask

  // Largest in-range values, the exact limits and saturation, odd sign bytes.
  task automatic test_extremes();
    bytes_t q;
    send_bytes(to_bytes("L,8959.99999,N,17959.99999,E\r"));
    send_bytes(to_bytes("L,9000.00000,S,18000.00000,W\r"));
    send_bytes(to_bytes("L,9000.00001,N,18000.00001,E\r"));
    send_bytes(to_bytes("L,9999.99999,S,99999.99999,W\r"));
    q = to_bytes("L,1234.56789,N,12345.67890,E\r");
    q[NS_OFS + 1] = 8'hFF;
    q[EW_OFS + 1] = 8'h00;
    send_bytes(q);
    q = to_bytes("L,0000.00001,n,00000.00002,e\r");
    send_bytes(q);
  endtask

  // Bytes that are not digits in digit positions count as zero.
  task automatic test_non_digits();
    bytes_t q;
    q = to_bytes("L,12:4.5/789,N,1A3B5.6 890,E\r");
    q[2] = 8'h00;
    q[22] = 8'hFF;
    send_bytes(q);
  endtask

  // A 'V' anywhere in the sentence clears the fix and zeroes the position.
  task automatic test_invalid();
    send_bytes(to_bytes("L,4916.45000,N,12311.12000,W,225444.00,V\r"));
    send_bytes(to_bytes("L,49V6.45000,N,12311.12000,E\r"));
    send_bytes(to_bytes("LV\r"));
  endtask

  // A second 'L' restarts the capture from the start of the buffer.
  task automatic test_restart();
    send_bytes(to_bytes("L,1111.11111,N,L,2222.22222,S,02222.22222,W\r"));
  endtask

  // Bytes past the buffer end are dropped, but a 'V' there still counts.
  task automatic test_buffer_full();
    bytes_t q;
    q = to_bytes("L,3030.30303,N,03030.30303,E,");
    repeat (DEPTH) q.push_back(8'h39);
    q.push_back(CHAR_CR);
    send_bytes(q);
    q = to_bytes("L,4040.40404,S,04040.40404,W,");
    repeat (DEPTH) q.push_back(8'h41);
    q.push_back(CHAR_V);
    q.push_back(CHAR_CR);
    send_bytes(q);
  endtask

  // Short sentences read whatever the previous one left at the field offsets.
  task automatic test_short_sentence();
    send_bytes(to_bytes("L,33\r"));
    send_bytes(to_bytes("L\r"));
  endtask

  // Outside a capture, carriage returns and 'V' do nothing.
  task automatic test_outside_capture();
    send_bytes(to_bytes("\r\nV\r,1234.5,N\r"));
    send_byte(8'hFF);
    send_byte(8'h00);
    send_bytes(to_bytes("L,5555.55555,N,05555.55555,E\r"));
  endtask

  // The receiver holds off for a long stretch while sentences keep coming.
  task automatic test_back_pressure();
    no_gaps = 1'b1;
    hold_request = 1'b1;
    repeat (20) begin
      send_bytes(to_bytes("L\r"));
    end
    repeat (4) begin
      send_bytes(random_sentence());
      send_byte(CHAR_CR);
    end
    no_gaps = 1'b0;
  endtask

  // Mostly well-formed sentences with random content, some broken, some noise.
  task automatic test_random_traffic();
    bytes_t q;
    int unsigned goal;
    int unsigned keep;
    goal = captured_count + RANDOM_ITEMS;
    while (captured_count < goal) begin
      // Now and then switch to a stretch without idling on either side.
      if ($urandom_range(0, 15) == 0) begin
        no_gaps = ($urandom_range(0, 2) == 0);
        quiet_rx = ($urandom_range(0, 2) == 0);
      end
      q = random_sentence();
      case ($urandom_range(0, 9))
        0: begin
          q.delete();
          repeat ($urandom_range(1, 8)) q.push_back(8'($urandom_range(0, 255)));
        end
        1: q[$urandom_range(6, q.size() - 1)] = CHAR_V;
        2: begin
          repeat ($urandom_range(1, 3)) q[$urandom_range(6, q.size() - 1)] =
            8'($urandom_range(0, 255));
        end
        3: begin
          repeat ($urandom_range(30, 60)) q.push_back(8'($urandom_range(8'h20, 8'h7E)));
        end
        4: begin
          keep = $urandom_range(7, q.size() - 1);
          while (q.size() > keep) void'(q.pop_back());
        end
        default: ;
      endcase
      q.push_back(CHAR_CR);
      q.push_back(8'h0A);
      send_bytes(q);
    end
    no_gaps = 1'b0;
    quiet_rx = 1'b0;
  endtask

  // Result sink: random stalls, one long hold on request, field checks.
  initial begin : result_sink
    int unsigned n;
    position_t want;
    forever begin
      if (hold_request) begin
        n = HOLD_CYCLES;
        hold_request = 1'b0;
      end else begin
        n = quiet_rx ? 0 : $urandom_range(0, 10);
      end
      if (n > 0) begin
        out_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (out_valid_o !== 1'b1);
      if (pending_fixes.size() == 0) begin
        $display("%0t: unexpected position lat=%0d lon=%0d valid=%0b", $time,
                 latitude_e7_o, longitude_e7_o, position_valid_o);
        mismatch_count++;
      end else begin
        want = pending_fixes.pop_front();
        if (latitude_e7_o !== want.lat) begin
          $display("%0t: latitude expected %0d actual %0d", $time, want.lat, latitude_e7_o);
          mismatch_count++;
        end
        if (longitude_e7_o !== want.lon) begin
          $display("%0t: longitude expected %0d actual %0d", $time, want.lon,
                   longitude_e7_o);
          mismatch_count++;
        end
        if (position_valid_o !== want.valid) begin
          $display("%0t: valid flag expected %0b actual %0b", $time, want.valid,
                   position_valid_o);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog on the total run length.
  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("%0t: timeout with %0d positions outstanding", $time, pending_fixes.size());
    $display("FAIL");
    $finish;
  end

  // Test sequence.
  initial begin
    foreach (sentence_buf[i]) begin
      sentence_buf[i] = 8'h00;
    end
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_full_sentence();
    test_extremes();
    test_non_digits();
    test_invalid();
    test_restart();
    test_buffer_full();
    test_short_sentence();
    test_outside_capture();
    test_back_pressure();
    test_random_traffic();
    in_valid_i <= 1'b0;
    while (pending_fixes.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

@@ sim.f @@
src/nglp_pkg.sv
src/nglp_front.sv
src/nglp_queue.sv
src/nglp_back.sv
src/nmea_gll_position_parser.sv
test/testbench.sv
